// ===== rtl/meu_pkg.sv =====
// Package for the MIPS execute unit: operation codes and the sequencer control struct.
// No dependencies.
package meu_pkg;
    localparam logic [5:0] OP_ADD    = 6'd1;
    localparam logic [5:0] OP_SUB    = 6'd2;
    localparam logic [5:0] OP_MUL    = 6'd3;
    localparam logic [5:0] OP_MULU   = 6'd4;
    localparam logic [5:0] OP_DIV    = 6'd5;
    localparam logic [5:0] OP_DIVU   = 6'd6;
    localparam logic [5:0] OP_REM    = 6'd7;
    localparam logic [5:0] OP_REMU   = 6'd8;
    localparam logic [5:0] OP_XOR    = 6'd9;
    localparam logic [5:0] OP_NEG    = 6'd10;
    localparam logic [5:0] OP_MOVE   = 6'd11;
    localparam logic [5:0] OP_LI     = 6'd12;
    localparam logic [5:0] OP_SEQ    = 6'd13;
    localparam logic [5:0] OP_SNE    = 6'd14;
    localparam logic [5:0] OP_SLT    = 6'd15;
    localparam logic [5:0] OP_SLE    = 6'd16;
    localparam logic [5:0] OP_SGT    = 6'd17;
    localparam logic [5:0] OP_SGE    = 6'd18;
    localparam logic [5:0] OP_LA     = 6'd19;
    localparam logic [5:0] OP_MULT   = 6'd20;
    localparam logic [5:0] OP_MULTU  = 6'd21;
    localparam logic [5:0] OP_DIVHL  = 6'd22;
    localparam logic [5:0] OP_DIVUHL = 6'd23;
    localparam logic [5:0] OP_MFHI   = 6'd24;
    localparam logic [5:0] OP_MFLO   = 6'd25;
    localparam logic [5:0] OP_BEQ    = 6'd26;
    localparam logic [5:0] OP_BNE    = 6'd27;
    localparam logic [5:0] OP_BLT    = 6'd28;
    localparam logic [5:0] OP_BLE    = 6'd29;
    localparam logic [5:0] OP_BGT    = 6'd30;
    localparam logic [5:0] OP_BGE    = 6'd31;
    localparam logic [5:0] OP_J      = 6'd32;
    localparam logic [5:0] OP_JAL    = 6'd33;
    localparam logic [5:0] OP_JR     = 6'd34;
    localparam logic [5:0] OP_JALR   = 6'd35;

    typedef struct packed {
        logic start;
        logic is_div;
        logic is_signed;
    } md_ctrl_t;
endpackage

// ===== rtl/meu_muldiv.sv =====
// Shared iterative multiply/divide unit: one shift-add or shift-subtract step per cycle.
// Depends on meu_pkg.
module meu_muldiv #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  meu_pkg::md_ctrl_t     ctrl,
    input  logic [DATA_WIDTH-1:0] op_a,
    input  logic [DATA_WIDTH-1:0] op_b,
    output logic                  done,
    output logic [DATA_WIDTH-1:0] res_hi,
    output logic [DATA_WIDTH-1:0] res_lo,
    output logic                  dz
);
    import meu_pkg::*;
    localparam int CW = $clog2(DATA_WIDTH + 1);
    localparam int W  = DATA_WIDTH;

    logic          busy_reg;
    logic [CW-1:0] cnt_reg;
    logic          div_reg, neg_q_reg, neg_r_reg, fin_reg, dz_reg;
    logic [W-1:0]  acc_reg, sh_reg, mc_reg;

    logic [W-1:0] abs_a, abs_b;
    logic [W:0]   sum, trial;
    logic [W-1:0] rem_s;
    logic         a_neg, b_neg;

    assign a_neg = ctrl.is_signed & op_a[W-1];
    assign b_neg = ctrl.is_signed & op_b[W-1];
    assign abs_a = a_neg ? (~op_a + 1'b1) : op_a;
    assign abs_b = b_neg ? (~op_b + 1'b1) : op_b;
    assign sum   = {1'b0, acc_reg} + {1'b0, (sh_reg[0] ? mc_reg : {W{1'b0}})};
    assign rem_s = {acc_reg[W-2:0], sh_reg[W-1]};
    assign trial = {acc_reg[W-1], rem_s} - {1'b0, mc_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            cnt_reg  <= '0;
        end else if (ctrl.start) begin
            busy_reg  <= 1'b1;
            fin_reg   <= 1'b0;
            cnt_reg   <= CW'(W);
            div_reg   <= ctrl.is_div;
            neg_q_reg <= a_neg ^ b_neg;
            neg_r_reg <= a_neg;
            dz_reg    <= ctrl.is_div & (op_b == '0);
            acc_reg   <= '0;
            sh_reg    <= ctrl.is_div ? abs_a : op_a;
            mc_reg    <= ctrl.is_div ? abs_b : op_b;
        end else if (busy_reg) begin
            if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (div_reg) begin
                    if (!trial[W]) begin
                        acc_reg <= trial[W-1:0];
                        sh_reg  <= {sh_reg[W-2:0], 1'b1};
                    end else begin
                        acc_reg <= rem_s;
                        sh_reg  <= {sh_reg[W-2:0], 1'b0};
                    end
                end else begin
                    acc_reg <= sum[W:1];
                    sh_reg  <= {sum[0], sh_reg[W-1:1]};
                end
            end else begin
                busy_reg <= 1'b0;
                fin_reg  <= 1'b1;
                if (div_reg) begin
                    if (dz_reg) begin
                        acc_reg <= '0;
                        sh_reg  <= '0;
                    end else begin
                        if (neg_q_reg) sh_reg  <= ~sh_reg + 1'b1;
                        if (neg_r_reg) acc_reg <= ~acc_reg + 1'b1;
                    end
                end
            end
        end else begin
            fin_reg <= 1'b0;
        end
    end

    assign done   = fin_reg;
    assign res_hi = acc_reg;
    assign res_lo = sh_reg;
    assign dz     = dz_reg;
endmodule

// ===== rtl/mips_execute_unit.sv =====
// Top level of the MIPS execute unit: sequencer, combinational ALU paths, hi/lo and output beat.
// Depends on meu_pkg and meu_muldiv.
// Simple operations, compares, branches and jumps offer their result beat in the cycle after
// the input beat, as their result is registered when the input beat is taken. Multiply,
// divide and remainder run on one shared shift-add/subtract unit at one step per bit: the
// unit loads its operands, steps through the bits and signals done, and the sequencer then
// offers the result beat, which waits on any result-side stall. Signed products use the unsigned loop
// with a sign correction of the high word. One item at a time: the input is not ready
// while an item is at work or its result beat waits.
module mips_execute_unit #(
    parameter int DATA_WIDTH = 32,
    parameter int PC_BITS    = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [5:0]         s_func,
    input  logic signed [31:0] s_operand_a,
    input  logic signed [31:0] s_operand_b,
    input  logic [15:0]        s_branch_target,
    input  logic [15:0]        s_current_pc,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_result,
    output logic               m_result_valid,
    output logic               m_link_write,
    output logic               m_jump_taken,
    output logic [15:0]        m_jump_target,
    output logic               m_div_by_zero
);
    import meu_pkg::*;
    localparam int W = DATA_WIDTH;
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MD   = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    logic [1:0]  state_reg, state_next;
    logic [W-1:0] hi_reg, lo_reg;
    logic [5:0]  func_reg;
    logic [W-1:0] a_reg, b_reg;
    logic [31:0] res_reg;
    logic        rv_reg, lnk_reg, jmp_reg, dz_reg;
    logic [15:0] jt_reg;

    logic [W-1:0] ua, ub;
    logic signed [W-1:0] sa, sb;
    logic        is_md, md_div, md_sgn, md_to_hilo;
    md_ctrl_t    mctl;
    logic        md_done, md_dz;
    logic [W-1:0] md_hi, md_lo, hi_fix;
    logic [W-1:0] alu;
    logic        av, al, aj, cond;
    logic [PC_BITS-1:0] link, tgt, rtgt;

    assign ua = s_operand_a[W-1:0];
    assign ub = s_operand_b[W-1:0];
    assign sa = ua;
    assign sb = ub;

    always_comb begin
        is_md  = 1'b0;
        md_div = 1'b0;
        md_sgn = 1'b0;
        case (s_func)
            OP_MUL, OP_MULU, OP_MULTU: is_md = 1'b1;
            OP_MULT: begin is_md = 1'b1; md_sgn = 1'b1; end
            OP_DIV, OP_REM, OP_DIVHL: begin
                is_md = 1'b1; md_div = 1'b1; md_sgn = 1'b1;
            end
            OP_DIVU, OP_REMU, OP_DIVUHL: begin is_md = 1'b1; md_div = 1'b1; end
            default: ;
        endcase
    end

    assign s_ready    = (state_reg == ST_IDLE);
    assign mctl.start = s_valid & s_ready & is_md;
    assign mctl.is_div = md_div;
    assign mctl.is_signed = md_sgn;

    meu_muldiv #(.DATA_WIDTH(W)) u_md (
        .aclk(aclk), .aresetn(aresetn), .ctrl(mctl), .op_a(ua), .op_b(ub),
        .done(md_done), .res_hi(md_hi), .res_lo(md_lo), .dz(md_dz)
    );

    // signed product high word: unsigned high minus cross terms
    assign hi_fix = md_hi - (a_reg[W-1] ? b_reg : '0) - (b_reg[W-1] ? a_reg : '0);
    assign md_to_hilo = (func_reg == OP_MULT) || (func_reg == OP_MULTU) ||
                        (func_reg == OP_DIVHL) || (func_reg == OP_DIVUHL);

    assign link = PC_BITS'(s_current_pc) + 1'b1;
    assign tgt  = PC_BITS'(s_branch_target);
    assign rtgt = PC_BITS'(s_operand_a);

    always_comb begin
        alu  = '0;
        av   = 1'b0;
        al   = 1'b0;
        aj   = 1'b0;
        cond = 1'b0;
        case (s_func)
            OP_ADD, OP_LA: begin alu = ua + ub; av = 1'b1; end
            OP_SUB:  begin alu = ua - ub; av = 1'b1; end
            OP_XOR:  begin alu = ua ^ ub; av = 1'b1; end
            OP_NEG:  begin alu = '0 - ua; av = 1'b1; end
            OP_MOVE: begin alu = ua; av = 1'b1; end
            OP_LI:   begin alu = ub; av = 1'b1; end
            OP_SEQ:  begin alu = W'(sa == sb); av = 1'b1; end
            OP_SNE:  begin alu = W'(sa != sb); av = 1'b1; end
            OP_SLT:  begin alu = W'(sa < sb); av = 1'b1; end
            OP_SLE:  begin alu = W'(sa <= sb); av = 1'b1; end
            OP_SGT:  begin alu = W'(sa > sb); av = 1'b1; end
            OP_SGE:  begin alu = W'(sa >= sb); av = 1'b1; end
            OP_MFHI: begin alu = hi_reg; av = 1'b1; end
            OP_MFLO: begin alu = lo_reg; av = 1'b1; end
            OP_BEQ:  cond = (sa == sb);
            OP_BNE:  cond = (sa != sb);
            OP_BLT:  cond = (sa < sb);
            OP_BLE:  cond = (sa <= sb);
            OP_BGT:  cond = (sa > sb);
            OP_BGE:  cond = (sa >= sb);
            OP_J:    aj = 1'b1;
            OP_JAL:  begin aj = 1'b1; al = 1'b1; end
            OP_JR:   aj = 1'b1;
            OP_JALR: begin aj = 1'b1; al = 1'b1; end
            default: ;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_valid) state_next = is_md ? ST_MD : ST_OUT;
            ST_MD:   if (md_done) state_next = ST_OUT;
            ST_OUT:  if (m_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            hi_reg    <= '0;
            lo_reg    <= '0;
        end else begin
            state_reg <= state_next;
            if (s_valid && s_ready) begin
                func_reg <= s_func;
                a_reg    <= ua;
                b_reg    <= ub;
                rv_reg   <= av | al;
                lnk_reg  <= al;
                jmp_reg  <= aj | cond;
                dz_reg   <= 1'b0;
                jt_reg   <= '0;
                if (al)
                    res_reg <= 32'(link);
                else
                    res_reg <= 32'(signed'(alu));
                if (cond || s_func == OP_J || s_func == OP_JAL)
                    jt_reg <= 16'(tgt);
                else if (s_func == OP_JR || s_func == OP_JALR)
                    jt_reg <= 16'(rtgt);
            end
            if (state_reg == ST_MD && md_done) begin
                dz_reg <= md_dz;
                if (md_to_hilo) begin
                    rv_reg  <= 1'b0;
                    res_reg <= '0;
                    lo_reg  <= md_lo;
                    hi_reg  <= (func_reg == OP_MULT) ? hi_fix : md_hi;
                end else begin
                    rv_reg <= 1'b1;
                    if (func_reg == OP_REM || func_reg == OP_REMU)
                        res_reg <= 32'(signed'(md_hi));
                    else
                        res_reg <= 32'(signed'(md_lo));
                end
            end
        end
    end

    assign m_valid        = (state_reg == ST_OUT);
    assign m_result       = res_reg;
    assign m_result_valid = rv_reg;
    assign m_link_write   = lnk_reg;
    assign m_jump_taken   = jmp_reg;
    assign m_jump_target  = jt_reg;
    assign m_div_by_zero  = dz_reg;
endmodule
